FILE: sv/max_xor_subarray_trie_core_macros.svh
// Assertion macros used by the checker file of the max-XOR subarray core.
// Depends on nothing; expects clk and rst_n in the scope where a macro is used.
`ifndef MAX_XOR_SUBARRAY_TRIE_CORE_MACROS_SVH
`define MAX_XOR_SUBARRAY_TRIE_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MXST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Overlapping implication outside reset.
`define MXST_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define MXST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mxst_pkg.sv
// Package for the max-XOR subarray core: sizes, node layout, control structs.
// Depends on nothing; the interfaces, core, datapath, controller and checker use it.
`timescale 1ns / 1ps

package mxst_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_ITEMS  = 1024;

    // Node store: root plus one path per stored prefix, prefixes 0..MAX_ITEMS
    localparam int NODE_CAP = 1 + (MAX_ITEMS + 1) * VALUE_BITS;
    localparam int NODE_AW  = $clog2(NODE_CAP);
    localparam int NCNT_W   = $clog2(NODE_CAP + 1);
    localparam int POS_W    = $clog2(MAX_ITEMS + 1);
    localparam int LVL_W    = $clog2(VALUE_BITS + 1);
    localparam int BIX_W    = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [NODE_AW-1:0]    node_addr_t;

    // A link of zero means no child; the root is never a child
    typedef struct packed {
        node_addr_t link1;
        node_addr_t link0;
        pos_t       latest;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic ins_begin;
        logic ins_zero;
        logic ins_step;
        logic qry_begin;
        logic qry_step;
        logic qry_end;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start;
        logic ovf;
        logic qry_last;
        logic ins_last;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: sv/mxst_in_if.sv
// Input channel of the max-XOR subarray core: valid/ready plus one item.
// Depends on mxst_pkg.
`timescale 1ns / 1ps

interface mxst_in_if;
    import mxst_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);
endinterface

FILE: sv/mxst_out_if.sv
// Result channel of the max-XOR subarray core: valid/ready plus one result.
// Depends on mxst_pkg.
`timescale 1ns / 1ps

interface mxst_out_if;
    import mxst_pkg::*;

    logic   valid;
    logic   ready;
    value_t best_value;
    pos_t   best_left;
    pos_t   best_right;
    logic   overflow;

    modport source (output valid, output best_value, output best_left, output best_right,
                    output overflow, input ready);
    modport sink   (input valid, input best_value, input best_left, input best_right,
                    input overflow, output ready);
endinterface

FILE: sv/max_xor_subarray_trie_core.sv
// Maximum-XOR subarray core: streams 31-bit values and, after every item,
// reports the best subarray XOR so far with its 1-based left and right ends.
// Items arrive one at a time and each is handled by two 31-level walks over
// one node memory with one read and one write port. An item that opens a
// sequence first inserts the zero prefix; an item beyond 1024 in a sequence
// skips both walks, is dropped and is answered with the held best and
// overflow set. The query walk reads one node per cycle, each address taken
// straight from the previous node's registered read data; the insert walk
// rewrites one node per cycle. A finished result waits in an output
// register, so a new item is taken while it is still unread; the block
// stalls before loading a second result until the first has left.
// Set first to open a new sequence; the first item after reset opens one in
// any case. The node memory needs no clearing pass: every node is written as
// it is allocated, before any read of it.
// Depends on mxst_pkg, mxst_in_if, mxst_out_if, mxst_ctrl, mxst_datapath.
`timescale 1ns / 1ps

module max_xor_subarray_trie_core (
    input  logic       clk,
    input  logic       rst_n,
    mxst_in_if.sink    in_ch,
    mxst_out_if.source out_ch
);
    import mxst_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer: owns the input handshake and steps the walks
    mxst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath: trie store, prefix and best record; drives the result channel
    mxst_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_value       (in_ch.value),
        .in_first       (in_ch.first),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .out_best_value (out_ch.best_value),
        .out_best_left  (out_ch.best_left),
        .out_best_right (out_ch.best_right),
        .out_overflow   (out_ch.overflow)
    );
endmodule

FILE: sv/mxst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mxst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: sv/mxst_datapath.sv
// Datapath of the max-XOR subarray core: prefix, trie node store, walk
// registers, best record and result register. Depends on mxst_pkg, mxst_ram.
`timescale 1ns / 1ps

module mxst_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  mxst_pkg::dp_cmd_t cmd,
    output mxst_pkg::dp_sts_t sts,
    input  mxst_pkg::value_t in_value,
    input  logic             in_first,
    input  logic             out_ready,
    output logic             out_valid,
    output mxst_pkg::value_t out_best_value,
    output mxst_pkg::pos_t   out_best_left,
    output mxst_pkg::pos_t   out_best_right,
    output logic             out_overflow
);
    import mxst_pkg::*;

    // Sequence state
    value_t              prefix_reg;
    pos_t                position_reg;
    logic [NCNT_W-1:0]   nodes_used_reg;
    logic                start_reg;
    logic                ovf_reg;

    // Walk state
    logic [LVL_W-1:0]    level_reg;
    node_addr_t          node_reg;
    logic                fresh_reg;
    logic                zero_reg;
    value_t              acc_reg;

    // Best record and result register
    value_t              best_value_reg;
    pos_t                best_left_reg;
    pos_t                best_right_reg;
    logic                out_valid_reg;
    value_t              out_value_reg;
    pos_t                out_left_reg;
    pos_t                out_right_reg;
    logic                out_ovf_reg;

    // Node store port
    logic                wr_en;
    node_addr_t          wr_addr;
    node_t               wr_node;
    node_addr_t          rd_addr;
    logic [NODE_W-1:0]   rd_data;

    node_t               entry;
    logic [BIX_W-1:0]    bix;
    logic                leaf;
    pos_t                pos_next;
    logic                start_c;
    logic                ovf_c;

    // Query step
    logic                q_bit;
    node_addr_t          q_other;
    node_addr_t          q_same;
    logic                q_take;
    node_addr_t          q_next;

    // Insert step
    value_t              ins_key;
    pos_t                ins_idx;
    logic                i_bit;
    node_addr_t          i_child_old;
    logic                i_alloc;
    node_addr_t          i_child;

    mxst_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_CAP)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_node),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        // A freshly allocated node holds no children and is never read back
        entry    = fresh_reg ? '0 : node_t'(rd_data);
        bix      = BIX_W'(LVL_W'(VALUE_BITS - 1) - level_reg);
        leaf     = (level_reg == LVL_W'(VALUE_BITS));
        pos_next = position_reg + pos_t'(1);
        start_c  = in_first || (position_reg == '0);
        ovf_c    = !start_c && (position_reg >= pos_t'(MAX_ITEMS));

        q_bit   = prefix_reg[bix];
        q_other = q_bit ? entry.link0 : entry.link1;
        q_same  = q_bit ? entry.link1 : entry.link0;
        q_take  = (q_other != '0);
        if (q_take)
        begin
            q_next = q_other;
        end
        else if (q_same != '0)
        begin
            q_next = q_same;
        end
        else
        begin
            q_next = node_reg;
        end

        ins_key     = zero_reg ? '0 : prefix_reg;
        ins_idx     = zero_reg ? '0 : pos_next;
        i_bit       = ins_key[bix];
        i_child_old = i_bit ? entry.link1 : entry.link0;
        i_alloc     = (i_child_old == '0);
        i_child     = i_alloc ? nodes_used_reg[NODE_AW-1:0] : i_child_old;

        wr_en          = cmd.ins_step;
        wr_addr        = node_reg;
        wr_node        = entry;
        wr_node.latest = ins_idx;
        if (!leaf)
        begin
            if (i_bit)
            begin
                wr_node.link1 = i_child;
            end
            else
            begin
                wr_node.link0 = i_child;
            end
        end

        // Begin commands read the root, which sits at address zero
        priority if (cmd.qry_step)
        begin
            rd_addr = q_next;
        end
        else if (cmd.ins_step)
        begin
            rd_addr = i_child;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg     <= '0;
            position_reg   <= '0;
            nodes_used_reg <= NCNT_W'(1);
            best_value_reg <= '0;
            best_left_reg  <= pos_t'(1);
            best_right_reg <= pos_t'(1);
            out_valid_reg  <= 1'b0;
            level_reg      <= '0;
            fresh_reg      <= 1'b0;
            zero_reg       <= 1'b0;
            start_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                start_reg <= start_c;
                ovf_reg   <= ovf_c;
                if (start_c)
                begin
                    prefix_reg     <= in_value;
                    position_reg   <= '0;
                    nodes_used_reg <= NCNT_W'(1);
                    best_value_reg <= '0;
                    best_left_reg  <= pos_t'(1);
                    best_right_reg <= pos_t'(1);
                end
                else if (!ovf_c)
                begin
                    prefix_reg <= prefix_reg ^ in_value;
                end
            end

            if (cmd.ins_begin)
            begin
                level_reg <= '0;
                fresh_reg <= cmd.ins_zero;
                zero_reg  <= cmd.ins_zero;
            end

            if (cmd.qry_begin)
            begin
                level_reg <= '0;
                fresh_reg <= 1'b0;
            end

            if (cmd.qry_step)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end

            if (cmd.ins_step)
            begin
                level_reg <= level_reg + LVL_W'(1);
                if (!leaf)
                begin
                    fresh_reg <= i_alloc;
                    if (i_alloc)
                    begin
                        nodes_used_reg <= nodes_used_reg + NCNT_W'(1);
                    end
                end
            end

            if (cmd.qry_end)
            begin
                if ((position_reg == '0) || (acc_reg > best_value_reg))
                begin
                    best_value_reg <= acc_reg;
                    best_left_reg  <= entry.latest + pos_t'(1);
                    best_right_reg <= pos_next;
                end
            end

            if (cmd.out_load)
            begin
                if (!ovf_reg)
                begin
                    position_reg <= pos_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ins_begin || cmd.qry_begin)
        begin
            node_reg <= '0;
        end
        else if (cmd.qry_step)
        begin
            node_reg <= q_next;
        end
        else if (cmd.ins_step && !leaf)
        begin
            node_reg <= i_child;
        end

        if (cmd.qry_begin)
        begin
            acc_reg <= '0;
        end
        else if (cmd.qry_step)
        begin
            acc_reg[bix] <= q_take;
        end

        if (cmd.out_load)
        begin
            out_value_reg <= best_value_reg;
            out_left_reg  <= best_left_reg;
            out_right_reg <= best_right_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign sts.start    = start_reg;
    assign sts.ovf      = ovf_reg;
    assign sts.qry_last = (level_reg == LVL_W'(VALUE_BITS - 1));
    assign sts.ins_last = leaf;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_best_value = out_value_reg;
    assign out_best_left  = out_left_reg;
    assign out_best_right = out_right_reg;
    assign out_overflow   = out_ovf_reg;
endmodule

FILE: sv/mxst_ctrl.sv
// Controller of the max-XOR subarray core: sequences restart insert, query
// walk, insert walk and result load. Depends on mxst_pkg.
`timescale 1ns / 1ps

module mxst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output mxst_pkg::dp_cmd_t cmd,
    input  mxst_pkg::dp_sts_t sts
);
    import mxst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ZINS,
        S_QRY_BEGIN,
        S_QRY,
        S_QRY_END,
        S_INS,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.start)
                begin
                    cmd.ins_begin = 1'b1;
                    cmd.ins_zero  = 1'b1;
                    state_next    = S_ZINS;
                end
                else if (sts.ovf)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_QRY_BEGIN;
                end
            end
            S_ZINS:
            begin
                cmd.ins_step = 1'b1;
                if (sts.ins_last)
                begin
                    state_next = S_QRY_BEGIN;
                end
            end
            S_QRY_BEGIN:
            begin
                cmd.qry_begin = 1'b1;
                state_next    = S_QRY;
            end
            S_QRY:
            begin
                cmd.qry_step = 1'b1;
                if (sts.qry_last)
                begin
                    state_next = S_QRY_END;
                end
            end
            S_QRY_END:
            begin
                cmd.qry_end   = 1'b1;
                cmd.ins_begin = 1'b1;
                state_next    = S_INS;
            end
            S_INS:
            begin
                cmd.ins_step = 1'b1;
                if (sts.ins_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: sv/mxst_checker.sv
// Port-level checks for the max-XOR subarray core, bound to its top level.
// Depends on mxst_pkg and max_xor_subarray_trie_core_macros.svh.
`timescale 1ns / 1ps
`include "max_xor_subarray_trie_core_macros.svh"

module mxst_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input mxst_pkg::value_t best_value,
    input mxst_pkg::pos_t   best_left,
    input mxst_pkg::pos_t   best_right,
    input logic             overflow
);
    // Items accepted but not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign pend_next = pend_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `MXST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(best_value) && $stable(best_left) && $stable(best_right) && $stable(overflow), "stalled result changed")
    `MXST_ASSERT_IMPLIES(a_span_order, out_valid, best_left <= best_right, "best left beyond right")
    `MXST_ASSERT_IMPLIES(a_pos_nonzero, out_valid, (best_left != '0) && (best_right != '0), "zero position in result")
    `MXST_ASSERT_IMPLIES(a_no_invented, out_valid, pend_reg != 2'd0, "result with no item")
    `MXST_ASSERT(a_pend_bound, pend_reg != 2'd3, "too many items in flight")
endmodule

bind max_xor_subarray_trie_core mxst_checker u_mxst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .best_value (out_ch.best_value),
    .best_left  (out_ch.best_left),
    .best_right (out_ch.best_right),
    .overflow   (out_ch.overflow)
);
